FILE: hdl/entropy_bit_pool_defines.svh
// Assertion macros used by the entropy bit pool checker.
`ifndef ENTROPY_BIT_POOL_DEFINES_SVH
`define ENTROPY_BIT_POOL_DEFINES_SVH

// Check on every clock edge outside reset.
`define EBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define EBP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: hdl/ebp_pkg.sv
// Shared constants and types of the entropy bit pool.
package ebp_pkg;

  localparam int unsigned CMD_W          = 2;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned MAX_CHUNK_BITS = 64;
  localparam int unsigned POOL_BYTES_DEF = 512;

  localparam logic [CMD_W-1:0] CMD_GIVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARM  = 2'd2;

  // What a byte access does to the pool byte it reads.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_XOR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        mode;
    logic [7:0] mask;
    logic [7:0] bits;
    logic [2:0] off;
    logic [3:0] len;
  } bop_t;

endpackage

FILE: hdl/ebp_ram.sv
// Generic simple dual-port RAM with registered read.
module ebp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/entropy_bit_pool.sv
// Entropy bit pool: byte-wide pool memory with a read-modify-write sequencer.
//
//   channel  | handshake         | fields
//   ---------+-------------------+--------------------------------------------
//   request  | start / busy      | cmd, bit_count, give_data
//   result   | done (one cycle)  | ok, take_data, fill_level_out, wake
//
// A request is taken when start is high and busy low. Arm, a failed or empty
// take, an empty give and an unknown command answer from the decide state.
// A give or take that touches pool bytes steps through them in the run state
// and answers from the drain state; the pool RAM port handles one byte per
// cycle. done comes with busy already low, so the next request can enter while
// done is high. Reset clears fill level, fold position and wait threshold at
// once; the pool bytes are not cleared. Results cannot be stalled.
module entropy_bit_pool #(
  parameter int unsigned POOL_BYTES = ebp_pkg::POOL_BYTES_DEF,
  localparam int unsigned FILL_W = $clog2(POOL_BYTES * 8 + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ebp_pkg::CMD_W-1:0]   cmd,
  input  logic [ebp_pkg::COUNT_W-1:0] bit_count,
  input  logic [ebp_pkg::DATA_W-1:0]  give_data,
  output logic                       busy,
  output logic                       done,
  output logic                       ok,
  output logic [ebp_pkg::DATA_W-1:0]  take_data,
  output logic [FILL_W-1:0]          fill_level_out,
  output logic                       wake
);

  import ebp_pkg::*;

  localparam int unsigned POOL_BITS = POOL_BYTES * 8;
  localparam int unsigned POS_W     = $clog2(POOL_BITS);
  localparam int unsigned ADDR_W    = POS_W - 3;
  localparam logic [FILL_W-1:0]  POOL_BITS_F = FILL_W'(POOL_BITS);
  localparam logic [POS_W:0]     POOL_BITS_P = (POS_W + 1)'(POOL_BITS);
  localparam logic [FILL_W-1:0]  NO_REQUEST  = '1;
  localparam logic [COUNT_W-1:0] MAX_CHUNK   = COUNT_W'(MAX_CHUNK_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t               state;
  logic [CMD_W-1:0]     cmd_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [COUNT_W-1:0]   n_q;
  logic [FILL_W-1:0]    fill;
  logic [POS_W-1:0]     fold;
  logic [FILL_W-1:0]    thr;
  logic [POS_W-1:0]     seg_pos;
  logic [COUNT_W-1:0]   seg_left;
  logic [DATA_W-1:0]    seg_data;
  op_t                  seg_mode;
  logic [COUNT_W-1:0]   rest;
  logic [DATA_W-1:0]    tdata;
  logic [COUNT_W-1:0]   got;

  bop_t                 m_op;
  logic                 m_valid;
  logic [ADDR_W-1:0]    m_addr;
  logic                 fwd_hit;
  logic [7:0]           fwd_byte;

  logic [2:0]           off;
  logic [3:0]           room_b;
  logic [3:0]           k;
  logic [7:0]           mask;
  logic [7:0]           bits8;
  logic [POS_W:0]       pos_sum;
  logic [POS_W-1:0]     pos_next;
  logic [COUNT_W-1:0]   left_next;
  logic [DATA_W-1:0]    data_shift;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 issue;

  logic [7:0]           rd_data;
  logic [7:0]           byte_in;
  logic [7:0]           wr_data;
  logic                 we;
  logic [7:0]           ext;
  logic [DATA_W-1:0]    take_next;
  logic [COUNT_W-1:0]   got_next;

  logic [FILL_W-1:0]    room;
  logic [COUNT_W-1:0]   a_bits;
  logic [COUNT_W-1:0]   r_bits;
  logic                 take_ok;
  logic [FILL_W-1:0]    take_start;
  logic                 arm_ok;
  logic [COUNT_W-1:0]   n_clamp;

  assign busy    = (state != S_IDLE);
  assign n_clamp = (bit_count > MAX_CHUNK) ? MAX_CHUNK : bit_count;

  // Byte access for the current segment position.
  always_comb begin
    off        = seg_pos[2:0];
    room_b     = 4'd8 - {1'b0, off};
    k          = (seg_left < COUNT_W'(room_b)) ? seg_left[3:0] : room_b;
    mask       = 8'((((9'd1 << k) - 9'd1) << off));
    bits8      = (seg_data[7:0] << off) & mask;
    pos_sum    = {1'b0, seg_pos} + (POS_W + 1)'(k);
    pos_next   = (pos_sum == POOL_BITS_P) ? '0 : pos_sum[POS_W-1:0];
    left_next  = seg_left - COUNT_W'(k);
    data_shift = seg_data >> k;
    rd_addr    = seg_pos[POS_W-1:3];
    issue      = (state == S_RUN);
  end

  // Modify stage: merge the byte that came back and write it, or extract bits for a take.
  always_comb begin
    byte_in = fwd_hit ? fwd_byte : rd_data;
    case (m_op.mode)
      OP_WRITE: wr_data = (byte_in & ~m_op.mask) | m_op.bits;
      OP_XOR:   wr_data = byte_in ^ m_op.bits;
      default:  wr_data = byte_in;
    endcase
    we        = m_valid && (m_op.mode == OP_WRITE || m_op.mode == OP_XOR);
    ext       = (byte_in & m_op.mask) >> m_op.off;
    take_next = tdata;
    got_next  = got;
    if (m_valid && m_op.mode == OP_READ) begin
      take_next = tdata | (DATA_W'(ext) << got);
      got_next  = got + COUNT_W'(m_op.len);
    end
  end

  // Request decode.
  always_comb begin
    room       = POOL_BITS_F - fill;
    a_bits     = (FILL_W'(n_q) < room) ? n_q : COUNT_W'(room);
    r_bits     = n_q - a_bits;
    take_ok    = (fill >= FILL_W'(n_q));
    take_start = fill - FILL_W'(n_q);
    arm_ok     = (fill >= FILL_W'(cnt_q));
  end

  ebp_ram #(
    .WIDTH(8),
    .DEPTH(POOL_BYTES)
  ) u_pool (
    .clk  (clk),
    .we   (we),
    .waddr(m_addr),
    .wdata(wr_data),
    .re   (issue),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      m_valid <= issue;
      // RAM returns old data on a same-address read and write: forward.
      fwd_hit <= issue && we && (rd_addr == m_addr);
    end
    fwd_byte    <= wr_data;
    m_addr      <= rd_addr;
    m_op.mode   <= seg_mode;
    m_op.mask   <= mask;
    m_op.bits   <= bits8;
    m_op.off    <= off;
    m_op.len    <= k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      fold  <= '0;
      thr   <= NO_REQUEST;
      done  <= 1'b0;
    end else begin
      done  <= 1'b0;
      tdata <= take_next;
      got   <= got_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q    <= cmd;
            cnt_q    <= bit_count;
            n_q      <= n_clamp;
            seg_data <= give_data;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          tdata          <= '0;
          got            <= '0;
          take_data      <= '0;
          fill_level_out <= fill;
          wake           <= 1'b0;
          unique case (cmd_q)
            CMD_GIVE: begin
              fill <= fill + FILL_W'(a_bits);
              rest <= r_bits;
              if (a_bits != '0) begin
                seg_pos  <= POS_W'(fill);
                seg_left <= a_bits;
                seg_mode <= OP_WRITE;
                state    <= S_RUN;
              end else if (r_bits != '0) begin
                seg_pos  <= fold;
                seg_left <= r_bits;
                seg_mode <= OP_XOR;
                state    <= S_RUN;
              end else begin
                ok    <= 1'b1;
                done  <= 1'b1;
                state <= S_IDLE;
                if (fill >= thr) begin
                  wake <= 1'b1;
                  thr  <= NO_REQUEST;
                end
              end
            end
            CMD_TAKE: begin
              if (take_ok && n_q != '0) begin
                fill     <= take_start;
                seg_pos  <= POS_W'(take_start);
                seg_left <= n_q;
                seg_mode <= OP_READ;
                state    <= S_RUN;
              end else begin
                ok    <= take_ok;
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
            CMD_ARM: begin
              ok    <= arm_ok;
              done  <= 1'b1;
              state <= S_IDLE;
              if (!arm_ok && thr > FILL_W'(cnt_q)) begin
                thr <= FILL_W'(cnt_q);
              end
            end
            default: begin
              ok    <= 1'b0;
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_RUN: begin
          seg_pos  <= pos_next;
          seg_left <= left_next;
          seg_data <= data_shift;
          if (seg_mode == OP_XOR) begin
            fold <= pos_next;
          end
          if (left_next == '0) begin
            // Pool filled up: fold the rest of the request in.
            if (seg_mode == OP_WRITE && rest != '0) begin
              seg_pos  <= fold;
              seg_left <= rest;
              seg_mode <= OP_XOR;
              rest     <= '0;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          ok             <= 1'b1;
          done           <= 1'b1;
          take_data      <= take_next;
          fill_level_out <= fill;
          wake           <= 1'b0;
          state          <= S_IDLE;
          if (cmd_q == CMD_GIVE && fill >= thr) begin
            wake <= 1'b1;
            thr  <= NO_REQUEST;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/ebp_checker.sv
// Port-level checks of the entropy bit pool, bound to the top level.
`include "entropy_bit_pool_defines.svh"

module ebp_checker #(
  parameter int unsigned POOL_BYTES = ebp_pkg::POOL_BYTES_DEF,
  localparam int unsigned FILL_W = $clog2(POOL_BYTES * 8 + 1)
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      ok,
  input logic [ebp_pkg::DATA_W-1:0] take_data,
  input logic [FILL_W-1:0]         fill_level_out,
  input logic                      wake
);

  import ebp_pkg::*;

  localparam logic [FILL_W-1:0] POOL_BITS_F = FILL_W'(POOL_BYTES * 8);
  localparam logic [DATA_W-1:0] ZERO_DATA   = '0;

  `EBP_ASSERT_RST(a_rst_quiet, rst |=> !done && !busy, "result or busy right after reset")
  `EBP_ASSERT(a_start_busy, start && !busy |=> busy, "accepted request did not raise busy")
  `EBP_ASSERT(a_fail_zero, done && !ok |-> take_data == ZERO_DATA, "failed result carries data")
  `EBP_ASSERT(a_wake_ok, done && wake |-> ok, "wake on a result that is not ok")
  `EBP_ASSERT(a_fill_range, done |-> fill_level_out <= POOL_BITS_F, "fill level above pool size")

endmodule

bind entropy_bit_pool ebp_checker #(
  .POOL_BYTES(POOL_BYTES)
) u_ebp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .ok            (ok),
  .take_data     (take_data),
  .fill_level_out(fill_level_out),
  .wake          (wake)
);
